[rtl/core/ipw_pkg.sv]
// Shared types and constants for the wrapping integer power block.
// Used by the exponent cell chain and the top level; depends on nothing else.
`default_nettype none

package ipw_pkg;

    // Default operand width in bits
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [0:0] {
        IPW_IDLE,
        IPW_RUN
    } ipw_state_t;

    // Control shared by every cell of the exponent chain
    typedef struct packed {
        logic load;
        logic advance;
    } ipw_cell_ctrl_t;

    // What one cell hands to its lower neighbour
    typedef struct packed {
        logic live;
        logic ebit;
    } ipw_link_t;

endpackage

`default_nettype wire

[rtl/core/ipw_cell.sv]
// One cell of the exponent chain: holds one exponent bit and a live mark.
// Depends on ipw_pkg for the control and link structs.
`default_nettype none

module ipw_cell (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire ipw_pkg::ipw_cell_ctrl_t ctrl,
    input  wire logic                    load_bit,
    input  wire ipw_pkg::ipw_link_t      from_next,
    output ipw_pkg::ipw_link_t           link_out
);

    logic live_reg;
    logic ebit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= 1'b0;
        end else if (ctrl.load) begin
            live_reg <= 1'b1;
        end else if (ctrl.advance) begin
            live_reg <= from_next.live;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            ebit_reg <= load_bit;
        end else if (ctrl.advance) begin
            ebit_reg <= from_next.ebit;
        end
    end

    assign link_out.live = live_reg;
    assign link_out.ebit = ebit_reg;

endmodule

`default_nettype wire

[rtl/core/ipw_wrap_mul.sv]
// Wrapping multiplier: low DATA_WIDTH bits of a product, built from three
// half-width partial products. No package dependency.
`default_nettype none

module ipw_wrap_mul #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic [DATA_WIDTH-1:0] op_a,
    input  wire logic [DATA_WIDTH-1:0] op_b,
    output logic      [DATA_WIDTH-1:0] product
);

    localparam int HALF = (DATA_WIDTH + 1) / 2;
    localparam int UPPER = DATA_WIDTH - HALF;

    logic [HALF-1:0]       a_lo;
    logic [HALF-1:0]       b_lo;
    logic [UPPER-1:0]      a_hi;
    logic [UPPER-1:0]      b_hi;
    logic [2*HALF-1:0]     prod_ll;
    logic [DATA_WIDTH-1:0] prod_lh;
    logic [DATA_WIDTH-1:0] prod_hl;
    logic [UPPER-1:0]      cross_sum;

    assign a_lo = op_a[HALF-1:0];
    assign b_lo = op_b[HALF-1:0];
    assign a_hi = op_a[DATA_WIDTH-1:HALF];
    assign b_hi = op_b[DATA_WIDTH-1:HALF];

    // high-by-high term lands wholly above the kept bits: drop it
    assign prod_ll   = (2*HALF)'(a_lo) * (2*HALF)'(b_lo);
    assign prod_lh   = DATA_WIDTH'(a_lo) * DATA_WIDTH'(b_hi);
    assign prod_hl   = DATA_WIDTH'(a_hi) * DATA_WIDTH'(b_lo);
    assign cross_sum = prod_lh[UPPER-1:0] + prod_hl[UPPER-1:0];

    assign product = prod_ll[DATA_WIDTH-1:0] + {cross_sum, {HALF{1'b0}}};

endmodule

`default_nettype wire

[rtl/core/integer_power_wrap32.sv]
// Wrapping integer power: base ** exponent modulo 2**DATA_WIDTH.
//
// Input channel s_*: one item carries base and exponent. Output channel m_*:
// one item carries the power. Each accepted item gives exactly one result.
// The exponent is loaded into a chain of DATA_WIDTH cells that shifts one bit
// a cycle towards the square-and-multiply step, lowest bit first; a live mark
// travels with the bits and ends the run when the chain is empty.
// s_tready is high only while no item is in the chain; an item may be taken
// while the previous result still waits in the output register.
// When the receiver stalls, a finished result is held in the accumulator
// until the output register frees, and no new item is accepted meanwhile.
// Reset (aresetn low, synchronous) empties the chain and the output register.
// Depends on ipw_pkg, ipw_cell and ipw_wrap_mul.
`default_nettype none

module integer_power_wrap32 #(
    parameter int DATA_WIDTH = ipw_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // base [DATA_WIDTH-1:0], exponent [2*DATA_WIDTH-1:DATA_WIDTH]
    input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // power [DATA_WIDTH-1:0]
    output logic      [((DATA_WIDTH+7)/8)*8-1:0]       m_tdata
);

    import ipw_pkg::*;

    localparam int M_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    ipw_state_t            state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;
    logic [DATA_WIDTH-1:0] power_reg;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic [DATA_WIDTH-1:0] sq_reg, sq_next;

    logic [DATA_WIDTH-1:0] base;
    logic [DATA_WIDTH-1:0] exponent;
    logic [DATA_WIDTH-1:0] mul_acc;
    logic [DATA_WIDTH-1:0] mul_sq;

    logic                  accept;
    logic                  step_en;
    logic                  finish;
    ipw_cell_ctrl_t        cell_ctrl;
    ipw_link_t             chain_in  [DATA_WIDTH];
    ipw_link_t             chain_out [DATA_WIDTH];

    assign base     = s_tdata[DATA_WIDTH-1:0];
    assign exponent = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

    assign s_tready = (state_reg == IPW_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign cell_ctrl.load    = accept;
    assign cell_ctrl.advance = (state_reg == IPW_RUN);

    // Exponent chain: cell i takes its neighbour's bit; the top cell takes empty
    for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_chain
        if (i == DATA_WIDTH - 1) begin : g_top
            assign chain_in[i] = '{live: 1'b0, ebit: 1'b0};
        end else begin : g_mid
            assign chain_in[i] = chain_out[i+1];
        end

        ipw_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl),
            .load_bit  (exponent[i]),
            .from_next (chain_in[i]),
            .link_out  (chain_out[i])
        );
    end

    ipw_wrap_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul_acc (
        .op_a    (acc_reg),
        .op_b    (sq_reg),
        .product (mul_acc)
    );

    ipw_wrap_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul_sq (
        .op_a    (sq_reg),
        .op_b    (sq_reg),
        .product (mul_sq)
    );

    assign step_en = (state_reg == IPW_RUN) && chain_out[0].live;
    assign finish  = (state_reg == IPW_RUN) && !chain_out[0].live
                     && (!m_valid_reg || m_tready);

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        acc_next     = acc_reg;
        sq_next      = sq_reg;

        unique case (state_reg)
            IPW_IDLE: begin
                if (accept) begin
                    state_next = IPW_RUN;
                    acc_next   = DATA_WIDTH'(1);
                    sq_next    = base;
                end
            end
            IPW_RUN: begin
                if (step_en) begin
                    // multiply in the current square where this bit is set
                    if (chain_out[0].ebit) begin
                        acc_next = mul_acc;
                    end
                    sq_next = mul_sq;
                end
                if (finish) begin
                    state_next = IPW_IDLE;
                end
            end
            default: begin
                state_next = IPW_IDLE;
            end
        endcase

        if (finish) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IPW_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        sq_reg  <= sq_next;
        if (finish) begin
            power_reg <= acc_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(power_reg);

endmodule

`default_nettype wire

[rtl/core/ipw_checker.sv]
// Port-level checks for integer_power_wrap32, attached by the bind below.
// Depends only on the top level's ports.
`default_nettype none

module ipw_checker #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [((DATA_WIDTH+7)/8)*8-1:0]   m_tdata
);

    logic s_fire;

    assign s_fire = s_tvalid && s_tready;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // one item at a time in the chain
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("input taken again while an item is in the chain");

    // no result can appear straight after an item is taken
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after accept");

    // a fresh result frees the chain at the same edge
    a_free_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result delivered while the chain is still busy");

endmodule

bind integer_power_wrap32 ipw_checker #(.DATA_WIDTH(DATA_WIDTH)) u_ipw_checker (.*);

`default_nettype wire
